@@ rtl/fsla_pkg.sv @@
// ----------------------------------------------------------------------------
// fsla_pkg
// Shared types and constants for the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsla_pkg;

    // Default pool size and the fixed width of the slot fields
    localparam int SLOTS_DEF = 64;
    localparam int SLOT_W    = 6;
    // Wide enough to compare any slot index against SLOTS (up to 65536)
    localparam int CMP_W     = 17;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic init_wr;     // clearing pass: write one link entry
        logic do_free;     // accepted free transaction
        logic do_alloc;    // accepted allocate, head available: read its link
        logic do_miss;     // accepted allocate on an empty pool
        logic fetch_load;  // link read data valid: pop head, load result
    } fsla_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic init_last;   // clearing pass on its last entry
        logic head_ok;     // head holds a usable slot
        logic out_room;    // output register free or emptied this cycle
    } fsla_stat_t;

endpackage

`default_nettype wire

@@ rtl/fsla_ram.sv @@
// ----------------------------------------------------------------------------
// fsla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/fsla_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsla_ctrl
// Controller: sequences the clearing pass, transaction acceptance and the
// link fetch of an allocate.
// ----------------------------------------------------------------------------
`default_nettype none

module fsla_ctrl
    import fsla_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_operation,
    output logic            s_ready,
    input  wire fsla_stat_t stat,
    output fsla_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT  = 3'b001,
        ST_IDLE  = 3'b010,
        ST_FETCH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && stat.out_room;
    assign accept  = s_valid && s_ready;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (stat.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_operation == OP_FREE) begin
                        cmd.do_free = 1'b1;
                    end else if (stat.head_ok) begin
                        cmd.do_alloc = 1'b1;
                        state_next   = ST_FETCH;
                    end else begin
                        cmd.do_miss = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch_load = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fsla_dp.sv @@
// ----------------------------------------------------------------------------
// fsla_dp
// Datapath: head register, link store, clearing counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsla_dp
    import fsla_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SLOT_W-1:0] s_slot_index,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic      [SLOT_W-1:0] m_granted_slot,
    output logic                   m_status,
    input  wire fsla_cmd_t         cmd,
    output fsla_stat_t             stat
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    // Link layout: {valid, index}
    logic [LINK_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0]  init_cnt_reg, init_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_granted_slot_reg, m_granted_slot_next;
    logic              m_status_reg, m_status_next;

    logic [IDX_W-1:0]  head_idx;
    logic [CMP_W-1:0]  head_cmp;
    logic [CMP_W-1:0]  slot_cmp;
    logic              slot_in_range;
    logic [IDX_W-1:0]  slot_addr;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;
    logic [LINK_W-1:0] init_link;

    // Index views and range checks
    assign head_idx      = head_reg[IDX_W-1:0];
    assign head_cmp      = CMP_W'(head_idx);
    assign slot_cmp      = CMP_W'(s_slot_index);
    assign slot_in_range = slot_cmp < SLOTS_CMP;
    assign slot_addr     = slot_cmp[IDX_W-1:0];

    // Reset chain: entry i links to i-1, entry 0 is null
    assign init_link = (init_cnt_reg == '0) ? '0
                                            : {1'b1, init_cnt_reg - IDX_W'(1)};

    // Link store write: clearing pass or push on free
    assign ram_we    = cmd.init_wr || (cmd.do_free && slot_in_range);
    assign ram_waddr = cmd.init_wr ? init_cnt_reg : slot_addr;
    assign ram_wdata = cmd.init_wr ? init_link : head_reg;

    fsla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (head_idx),
        .rd_data (ram_rdata)
    );

    // Clearing counter
    assign init_cnt_next = cmd.init_wr ? init_cnt_reg + IDX_W'(1) : init_cnt_reg;

    // Head update: push, pop or drop an unusable head
    always_comb begin
        head_next = head_reg;
        if (cmd.do_free && slot_in_range) begin
            head_next = {1'b1, slot_addr};
        end else if (cmd.fetch_load) begin
            head_next = ram_rdata;
        end else if (cmd.do_miss) begin
            head_next = '0;
        end
    end

    // Result register
    always_comb begin
        m_valid_next        = m_valid_reg && !m_ready;
        m_granted_slot_next = m_granted_slot_reg;
        m_status_next       = m_status_reg;
        if (cmd.do_free) begin
            m_valid_next        = 1'b1;
            m_granted_slot_next = '0;
            m_status_next       = STATUS_DONE;
        end else if (cmd.do_miss) begin
            m_valid_next        = 1'b1;
            m_granted_slot_next = '0;
            m_status_next       = STATUS_EMPTY;
        end else if (cmd.fetch_load) begin
            m_valid_next        = 1'b1;
            m_granted_slot_next = head_cmp[SLOT_W-1:0];
            m_status_next       = STATUS_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= {1'b1, LAST_IDX};
            init_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            init_cnt_reg <= init_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_granted_slot_reg <= m_granted_slot_next;
        m_status_reg       <= m_status_next;
    end

    // Status to the controller
    assign stat.init_last = (init_cnt_reg == LAST_IDX);
    assign stat.head_ok   = head_reg[IDX_W] && (head_cmp < SLOTS_CMP);
    assign stat.out_room  = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_granted_slot = m_granted_slot_reg;
    assign m_status       = m_status_reg;

endmodule

`default_nettype wire

@@ rtl/fixed_slot_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Pool allocator for SLOTS fixed slots kept as a last-in-first-out free list.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_operation, s_slot_index
//  m_      | out       | m_valid / m_ready  | m_granted_slot, m_status
//
// A free and an allocate on an empty pool load the output register directly;
// an allocate first passes through ST_FETCH for the registered read of the
// head's link from the link store. After reset a clearing pass writes every
// link store entry to build the initial chain, with s_ready low. A result
// waits in the output register; a new transaction is taken once it empties.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_free_list_allocator
    import fsla_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_operation,
    input  wire logic [SLOT_W-1:0] s_slot_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [SLOT_W-1:0] m_granted_slot,
    output logic                   m_status
);

    fsla_cmd_t  cmd;
    fsla_stat_t stat;

    fsla_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    fsla_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_slot_index   (s_slot_index),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_granted_slot (m_granted_slot),
        .m_status       (m_status),
        .cmd            (cmd),
        .stat           (stat)
    );

`ifndef SYNTH
    // A link fetch only follows an accepted allocate
    a_fetch_after_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fetch_load |-> $past(cmd.do_alloc))
        else $error("link fetch without a preceding allocate");

    // Never accept while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid && !m_ready))
        else $error("input ready while result stalled");

    // An empty-pool allocate reports failure next cycle
    a_miss_status: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_miss |=> (m_valid && (m_status == STATUS_EMPTY)))
        else $error("failed allocate not reported");

    // A failed allocate hands out slot zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_EMPTY)) |-> (m_granted_slot == '0))
        else $error("failed allocate with non-zero slot");
`endif

endmodule

`default_nettype wire

@@ dv/fixed_slot_free_list_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_tb
// Self-checking bench for the free-list pool allocator. The bench keeps its
// own copy of the link store and the head. Every accepted transaction is
// predicted from that copy, and the granted slot and status of each result
// are compared in order. The stimulus starts with a few directed allocates
// and frees. Random episodes follow: mixed traffic on held slots, draining
// the pool to empty with refused allocates, and refilling in random order. A
// final stretch mixes allocates with frees of arbitrary slots, double frees included.
// Sender bursts and receiver stalls are random, with two long receiver
// hold-offs.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_slot_free_list_allocator_tb
    import fsla_pkg::*;
;

    localparam int NSLOT       = SLOTS_DEF;
    localparam int CYCLE_LIMIT = 300000;

    // One link: valid bit over a slot index
    typedef logic [SLOT_W:0] link_t;

    typedef struct packed {
        link_t [NSLOT-1:0] link;
        link_t             head;
    } pool_t;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic              drain;   // wait for all outstanding results first
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted;
        logic              status;
    } grant_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_operation  = OP_ALLOC;
    logic [SLOT_W-1:0] s_slot_index = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [SLOT_W-1:0] m_granted_slot;
    logic              m_status;

    fixed_slot_free_list_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_slot_index   (s_slot_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_granted_slot (m_granted_slot),
        .m_status       (m_status)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shared bench state
    req_t   req_q[$];          // transactions waiting to be offered
    grant_t grant_q[$];        // predicted results, oldest first
    pool_t  pool_model;        // free list as seen by the checker
    pool_t  gen_pool;          // free list as tracked while building stimulus
    int     held[$];           // slots handed out, as tracked while building
    logic   feed_done   = 1'b0;
    int     errors      = 0;
    int     n_alloc     = 0;
    int     n_free      = 0;
    int     n_refused   = 0;
    int     results_seen = 0;
    int     cycles      = 0;

    // Free list after reset: slot N-1 at the head, chain running down to 0
    function automatic pool_t pool_reset();
        pool_t st;
        int    i;
        st.link[0] = '0;
        for (i = 1; i < NSLOT; i++)
            st.link[i] = {1'b1, SLOT_W'(i - 1)};
        st.head = {1'b1, SLOT_W'(NSLOT - 1)};
        return st;
    endfunction

    // One allocate or free applied to a free list, with its result
    task automatic pool_step(inout pool_t st, input logic op,
                             input logic [SLOT_W-1:0] idx, output grant_t res);
        res.granted = '0;
        res.status  = STATUS_DONE;
        if (op == OP_ALLOC) begin
            if (st.head[SLOT_W]) begin
                res.granted = st.head[SLOT_W-1:0];
                st.head     = st.link[st.head[SLOT_W-1:0]];
            end else begin
                res.status = STATUS_EMPTY;
            end
        end else if (int'(idx) < NSLOT) begin
            // pushed back unchecked, double frees included
            st.link[idx] = st.head;
            st.head      = {1'b1, idx};
        end
    endtask

    // Queue a transaction and keep track of which slots are held
    task automatic add_req(input logic op, input logic [SLOT_W-1:0] idx,
                           input logic drain);
        grant_t g;
        req_t   r;
        int     k;
        pool_step(gen_pool, op, idx, g);
        if (op == OP_ALLOC) begin
            if (g.status == STATUS_DONE)
                held.push_back(int'(g.granted));
        end else begin
            for (k = 0; k < held.size(); k++) begin
                if (held[k] == int'(idx)) begin
                    held.delete(k);
                    break;
                end
            end
        end
        r.op    = op;
        r.slot  = idx;
        r.drain = drain;
        req_q.push_back(r);
    endtask

    task automatic free_held(input logic drain);
        int k;
        k = $urandom_range(held.size() - 1);
        add_req(OP_FREE, SLOT_W'(held[k]), drain);
    endtask

    // Driver: bursts of random length with random gaps in between
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_p
        grant_t g;
        req_t   r;
        logic   slot_free;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            s_operation  <= OP_ALLOC;
            s_slot_index <= '0;
        end else begin
            slot_free = !s_valid || s_ready;
            // transaction accepted: predict its result
            if (s_valid && s_ready) begin
                pool_step(pool_model, s_operation, s_slot_index, g);
                grant_q.push_back(g);
                if (s_operation == OP_ALLOC) n_alloc++;
                else n_free++;
                if (g.status == STATUS_EMPTY) n_refused++;
            end
            if (slot_free) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (req_q.size() == 0) begin
                    s_valid   <= 1'b0;
                    feed_done <= 1'b1;
                end else if (req_q[0].drain && grant_q.size() != 0) begin
                    s_valid <= 1'b0;
                end else begin
                    r = req_q.pop_front();
                    s_valid      <= 1'b1;
                    s_operation  <= r.op;
                    s_slot_index <= r.slot;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall rate changes phase by phase, plus two long hold-offs
    int hold_left  = 0;
    int holds_done = 0;
    int phase_left = 0;
    int stall_pct  = 0;

    always @(posedge aclk) begin : sink_p
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (holds_done < 2 && results_seen >= 200 + holds_done * 400) begin
            hold_left  <= 300;
            holds_done <= holds_done + 1;
            m_ready    <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                phase_left <= $urandom_range(20, 120);
                case ($urandom_range(3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                phase_left <= phase_left - 1;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_p
        grant_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (grant_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: granted_slot %0d status %0d",
                         $time, m_granted_slot, m_status);
            end else begin
                want = grant_q.pop_front();
                if (m_granted_slot !== want.granted) begin
                    errors++;
                    $display("%0t: granted_slot expected %0d, got %0d",
                             $time, want.granted, m_granted_slot);
                end
                if (m_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_status);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, grant_q.size());
            $display("fixed_slot_free_list_allocator_tb failed");
            $finish;
        end
    end

    // Stimulus build, reset and end of run
    initial begin : main_p
        int   ep;
        int   n;
        int   k;
        logic drain;
        pool_model = pool_reset();
        gen_pool   = pool_reset();

        // Directed: first grants from the top of the chain, index ignored
        // on allocate, frees pushed back and handed out again
        add_req(OP_ALLOC, 6'd0,  1'b0);
        add_req(OP_ALLOC, 6'd63, 1'b0);
        add_req(OP_ALLOC, 6'd42, 1'b0);
        add_req(OP_ALLOC, 6'd21, 1'b0);
        add_req(OP_FREE,  6'd61, 1'b0);
        add_req(OP_FREE,  6'd63, 1'b0);
        add_req(OP_ALLOC, 6'd63, 1'b0);
        add_req(OP_ALLOC, 6'd0,  1'b0);
        add_req(OP_ALLOC, 6'd5,  1'b0);
        add_req(OP_FREE,  6'd62, 1'b1);
        add_req(OP_FREE,  6'd60, 1'b0);
        add_req(OP_ALLOC, 6'd0,  1'b0);
        add_req(OP_FREE,  6'd59, 1'b0);
        add_req(OP_FREE,  6'd60, 1'b0);

        // Random episodes on a well-formed list
        while (req_q.size() < 900) begin
            ep    = $urandom_range(3);
            drain = 1'($urandom_range(1));
            case (ep)
                0, 1: begin
                    n = $urandom_range(20, 80);
                    for (k = 0; k < n; k++) begin
                        if (held.size() == 0 || $urandom_range(99) < 55)
                            add_req(OP_ALLOC, SLOT_W'($urandom), drain && k == 0);
                        else
                            free_held(drain && k == 0);
                    end
                end
                2: begin
                    // drain the pool, then a few refused allocates
                    add_req(OP_ALLOC, SLOT_W'($urandom), drain);
                    while (gen_pool.head[SLOT_W])
                        add_req(OP_ALLOC, SLOT_W'($urandom), 1'b0);
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        add_req(OP_ALLOC, SLOT_W'($urandom), 1'b0);
                end
                default: begin
                    // hand every held slot back in random order
                    n = held.size();
                    for (k = 0; k < n; k++)
                        free_held(drain && k == 0);
                end
            endcase
        end

        // Noise: allocates mixed with frees of arbitrary slots, double frees included
        for (k = 0; k < 100; k++) begin
            if ($urandom_range(1) == 0)
                add_req(OP_ALLOC, SLOT_W'($urandom), k == 0);
            else
                add_req(OP_FREE, SLOT_W'($urandom_range(NSLOT - 1)), k == 0);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(feed_done && grant_q.size() == 0))
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (grant_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, grant_q.size());
        end
        $display("Covered %0d allocates and %0d frees, %0d refused on an empty pool;",
                 n_alloc, n_free, n_refused);
        $display("%0d results checked, %0d mismatches, two long receiver hold-offs.",
                 results_seen, errors);
        if (errors == 0)
            $display("fixed_slot_free_list_allocator_tb passed");
        else
            $display("fixed_slot_free_list_allocator_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fsla_pkg.sv
rtl/fsla_ram.sv
rtl/fsla_ctrl.sv
rtl/fsla_dp.sv
rtl/fixed_slot_free_list_allocator.sv
dv/fixed_slot_free_list_allocator_tb.sv
